@@ rtl/lrfp_pkg.sv @@
// Shared types and constants of the laser range frame poller.
`default_nettype none

package lrfp_pkg;

   // Sizing defaults for the top-level parameters
   localparam int COUNTER_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   // Control and status register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLED          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_DELAY      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INIT_GAP         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLE_PERIOD    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESPONSE_TIMEOUT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STALE_TIMEOUT    = 3'd5;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] START_DELAY_RESET      = 16'd100;
   localparam logic [CSR_DATA_BITS-1:0] INIT_GAP_RESET         = 16'd180;
   localparam logic [CSR_DATA_BITS-1:0] SAMPLE_PERIOD_RESET    = 16'd100;
   localparam logic [CSR_DATA_BITS-1:0] RESPONSE_TIMEOUT_RESET = 16'd160;
   localparam logic [CSR_DATA_BITS-1:0] STALE_TIMEOUT_RESET    = 16'd900;

   // Item commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Request codes towards the rangefinder
   localparam logic [1:0] SEND_NONE     = 2'd0;
   localparam logic [1:0] SEND_LASER_ON = 2'd1;
   localparam logic [1:0] SEND_MEASURE  = 2'd2;

   localparam logic [13:0] AGE_MAX = 14'd9999;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  send_request;
      logic        new_measurement;
      logic [19:0] distance_mm;
      logic        distance_valid;
      logic [13:0] age_ms;
      logic        awaiting_reply;
   } rsp_item_type;

   // Classified item handed from the front end to the back end
   typedef struct packed {
      logic       is_tick;
      logic [7:0] rx_byte;
      logic       digit_or_dot;
   } work_item_type;

endpackage

`default_nettype wire

@@ rtl/laser_range_frame_poller.sv @@
// Top level of the laser range frame poller: front end, work queue and back end.
// A result passes through the work queue and then the result queue before it reaches the rsp_ ports.
// Throughput: one item per cycle while the result queue is not full.
// Result queue and work queue each hold QUEUE_DEPTH entries.
// Reset (synchronous, active high) empties both queues, loads register defaults
// and restarts the start sequence; there is no clearing pass.
`default_nettype none

module laser_range_frame_poller #(
   parameter int COUNTER_BITS = lrfp_pkg::COUNTER_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = lrfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Item channel
   input  wire logic                                push,
   input  wire lrfp_pkg::req_item_type              req_item,
   output logic                                     full,
   // Result channel
   input  wire logic                                pop,
   output logic                                     empty,
   output lrfp_pkg::rsp_item_type                   rsp_item,
   // Register writes
   input  wire logic                                csr_write_en,
   input  wire logic [lrfp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lrfp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                    work_valid;
   logic                    work_pop;
   lrfp_pkg::work_item_type work_item;

   // Front end: take each transfer, tag tick or byte, flag digit and dot characters
   // and hold the item in the work queue until the back end is free.
   lrfp_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_item   (req_item),
      .full       (full),
      .work_valid (work_valid),
      .work_item  (work_item),
      .work_pop   (work_pop)
   );

   // Back end: advance the frame window, the start sequence and the timers,
   // one item a cycle, and push each result into the result queue. It stalls
   // only while the result queue is full, so a waiting result never blocks
   // intake until both queues have filled.
   lrfp_back #(
      .COUNTER_BITS (COUNTER_BITS),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .work_valid   (work_valid),
      .work_item    (work_item),
      .work_pop     (work_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_item     (rsp_item)
   );

endmodule

`default_nettype wire

@@ rtl/lrfp_fifo.sv @@
// Small first-in first-out queue with registered entries.
`default_nettype none

module lrfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lrfp_front.sv @@
// Front end: takes items in, classifies them and queues them for the back end.
`default_nettype none

module lrfp_front #(
   parameter int QUEUE_DEPTH = lrfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire lrfp_pkg::req_item_type req_item,
   output logic                        full,
   output logic                        work_valid,
   output lrfp_pkg::work_item_type     work_item,
   input  wire logic                   work_pop
);

   lrfp_pkg::work_item_type classified;
   logic                    work_empty;

   // Tag the item kind and flag ASCII digits and the dot
   always_comb begin
      classified.is_tick      = (req_item.command == lrfp_pkg::CMD_TICK);
      classified.rx_byte      = req_item.rx_byte;
      classified.digit_or_dot = ((req_item.rx_byte >= 8'h30) && (req_item.rx_byte <= 8'h39))
                                || (req_item.rx_byte == 8'h2E);
   end

   lrfp_fifo #(
      .WIDTH ($bits(lrfp_pkg::work_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (classified),
      .full  (full),
      .pop   (work_pop),
      .rdata (work_item),
      .empty (work_empty)
   );

   assign work_valid = !work_empty;

endmodule

`default_nettype wire

@@ rtl/lrfp_back.sv @@
// Back end: frame matching, start sequence, request timing and result queue.
`default_nettype none

module lrfp_back #(
   parameter int COUNTER_BITS = lrfp_pkg::COUNTER_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = lrfp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [lrfp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lrfp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire logic                                 work_valid,
   input  wire lrfp_pkg::work_item_type              work_item,
   output logic                                      work_pop,
   input  wire logic                                 pop,
   output logic                                      empty,
   output lrfp_pkg::rsp_item_type                    rsp_item
);

   localparam logic [1:0]  STAGE_START = 2'd0;
   localparam logic [1:0]  STAGE_GAP   = 2'd1;
   localparam logic [1:0]  STAGE_RUN   = 2'd2;
   localparam logic [3:0]  WIN_LEN     = 4'd11;
   localparam logic [31:0] ACK_HEAD    = 32'h8006_8501;
   localparam int          DW          = lrfp_pkg::CSR_DATA_BITS;
   localparam int          CB          = COUNTER_BITS;

   // Configuration
   logic          enabled_ff;
   logic [DW-1:0] start_delay_ff, init_gap_ff, sample_period_ff;
   logic [DW-1:0] response_timeout_ff, stale_timeout_ff;

   // Working state
   logic [7:0]    win_ff [11];
   logic [7:0]    win_in [11];
   logic [7:0]    win_new [11];
   logic [10:0]   dod_ff, dod_in, dod_new;
   logic [3:0]    fill_ff, fill_in, fill_new;
   logic [7:0]    sum_ff, sum_in, sum_new;
   logic [31:0]   hist_ff, hist_in;
   logic [1:0]    stage_ff, stage_in;
   logic          pending_ff, pending_in;
   logic [CB-1:0] action_ff, action_in, action_dec;
   logic [CB-1:0] reply_ff, reply_in, reply_dec;
   logic          valid_ff, valid_in;
   logic [19:0]   dist_ff, dist_in;
   logic [13:0]   age_ff, age_in, age_inc;

   logic                   fire, out_full;
   logic [1:0]             send;
   logic                   fresh, ack_seen, frame_ok;
   logic [7:0]             rx;
   logic signed [21:0]     mm;
   lrfp_pkg::rsp_item_type result;

   function automatic logic signed [21:0] digit_value(input logic [7:0] c);
      logic [7:0]        t;
      logic signed [4:0] s;
      t = c - 8'd48;
      s = t[4:0];
      return 22'(s);
   endfunction

   assign fire     = work_valid && !out_full;
   assign work_pop = fire;
   assign rx       = work_item.rx_byte;

   // Window after taking the byte: append while filling, slide once full
   always_comb begin
      for (int i = 0; i < 11; i++) begin
         if (fill_ff == 4'(i)) begin
            win_new[i] = rx;
            dod_new[i] = work_item.digit_or_dot;
         end else if (fill_ff == WIN_LEN && i == 10) begin
            win_new[i] = rx;
            dod_new[i] = work_item.digit_or_dot;
         end else if (fill_ff == WIN_LEN) begin
            win_new[i] = win_ff[(i < 10) ? i + 1 : i];
            dod_new[i] = dod_ff[(i < 10) ? i + 1 : i];
         end else begin
            win_new[i] = win_ff[i];
            dod_new[i] = dod_ff[i];
         end
      end
   end

   // Running byte sum of the window, modulo 256
   assign sum_new  = (fill_ff == WIN_LEN) ? (sum_ff - win_ff[0] + rx) : (sum_ff + rx);
   assign fill_new = (fill_ff < WIN_LEN) ? fill_ff + 4'd1 : fill_ff;
   assign ack_seen = (fill_ff >= 4'd4) && (hist_ff == ACK_HEAD) && (rx == 8'hF4);

   // Frame checksum holds when all eleven bytes sum to zero
   assign frame_ok = (fill_new == WIN_LEN) && (win_new[0] == 8'h80) && (win_new[1] == 8'h06)
                     && ((win_new[2] == 8'h82) || (win_new[2] == 8'h83))
                     && (&dod_new[9:3]) && (sum_new == 8'h00);

   assign mm = digit_value(win_new[3]) * 22'sd100000 + digit_value(win_new[4]) * 22'sd10000
             + digit_value(win_new[5]) * 22'sd1000 + digit_value(win_new[7]) * 22'sd100
             + digit_value(win_new[8]) * 22'sd10 + digit_value(win_new[9]);

   assign action_dec = (action_ff != '0) ? action_ff - CB'(1) : action_ff;
   assign reply_dec  = (reply_ff != '0) ? reply_ff - CB'(1) : reply_ff;
   assign age_inc    = (age_ff < lrfp_pkg::AGE_MAX) ? age_ff + 14'd1 : age_ff;

   always_comb begin
      for (int i = 0; i < 11; i++) begin
         win_in[i] = win_ff[i];
      end
      dod_in     = dod_ff;
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      hist_in    = hist_ff;
      stage_in   = stage_ff;
      pending_in = pending_ff;
      action_in  = action_ff;
      reply_in   = reply_ff;
      valid_in   = valid_ff;
      dist_in    = dist_ff;
      age_in     = age_ff;
      send       = lrfp_pkg::SEND_NONE;
      fresh      = 1'b0;

      if (fire && enabled_ff) begin
         if (work_item.is_tick) begin
            action_in = action_dec;
            reply_in  = reply_dec;
            age_in    = age_inc;
            if (valid_ff && ({2'b00, age_inc} > stale_timeout_ff)) begin
               valid_in = 1'b0;
            end
            unique case (stage_ff)
               STAGE_START: begin
                  if (action_dec == '0) begin
                     fill_in   = '0;
                     sum_in    = '0;
                     send      = lrfp_pkg::SEND_LASER_ON;
                     stage_in  = STAGE_GAP;
                     action_in = CB'(init_gap_ff);
                  end
               end
               STAGE_GAP: begin
                  if (action_dec == '0) begin
                     stage_in  = STAGE_RUN;
                     action_in = CB'(40);
                  end
               end
               default: begin
                  if (pending_ff) begin
                     if (reply_dec == '0) begin
                        pending_in = 1'b0;
                     end
                  end else if (action_dec == '0) begin
                     fill_in    = '0;
                     sum_in     = '0;
                     send       = lrfp_pkg::SEND_MEASURE;
                     pending_in = 1'b1;
                     reply_in   = CB'(response_timeout_ff);
                     action_in  = CB'(sample_period_ff);
                  end
               end
            endcase
         end else begin
            hist_in = {hist_ff[23:0], rx};
            if (ack_seen) begin
               fill_in = '0;
               sum_in  = '0;
            end else if (frame_ok) begin
               fill_in = '0;
               sum_in  = '0;
               if (mm > 22'sd0) begin
                  dist_in    = mm[19:0];
                  valid_in   = 1'b1;
                  age_in     = '0;
                  pending_in = 1'b0;
                  fresh      = 1'b1;
               end
            end else begin
               for (int i = 0; i < 11; i++) begin
                  win_in[i] = win_new[i];
               end
               dod_in  = dod_new;
               fill_in = fill_new;
               sum_in  = sum_new;
            end
         end
      end
   end

   always_comb begin
      result.send_request    = send;
      result.new_measurement = fresh;
      result.distance_mm     = dist_in;
      result.distance_valid  = valid_in;
      result.age_ms          = valid_in ? age_in : lrfp_pkg::AGE_MAX;
      result.awaiting_reply  = pending_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff          <= 1'b1;
         start_delay_ff      <= lrfp_pkg::START_DELAY_RESET;
         init_gap_ff         <= lrfp_pkg::INIT_GAP_RESET;
         sample_period_ff    <= lrfp_pkg::SAMPLE_PERIOD_RESET;
         response_timeout_ff <= lrfp_pkg::RESPONSE_TIMEOUT_RESET;
         stale_timeout_ff    <= lrfp_pkg::STALE_TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lrfp_pkg::REG_ENABLED:          enabled_ff          <= csr_wdata[0];
            lrfp_pkg::REG_START_DELAY:      start_delay_ff      <= csr_wdata;
            lrfp_pkg::REG_INIT_GAP:         init_gap_ff         <= csr_wdata;
            lrfp_pkg::REG_SAMPLE_PERIOD:    sample_period_ff    <= csr_wdata;
            lrfp_pkg::REG_RESPONSE_TIMEOUT: response_timeout_ff <= csr_wdata;
            lrfp_pkg::REG_STALE_TIMEOUT:    stale_timeout_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         sum_ff     <= '0;
         stage_ff   <= STAGE_START;
         pending_ff <= 1'b0;
         action_ff  <= CB'(lrfp_pkg::START_DELAY_RESET);
         reply_ff   <= '0;
         valid_ff   <= 1'b0;
         dist_ff    <= '0;
         age_ff     <= '0;
      end else begin
         fill_ff    <= fill_in;
         sum_ff     <= sum_in;
         stage_ff   <= stage_in;
         pending_ff <= pending_in;
         action_ff  <= action_in;
         reply_ff   <= reply_in;
         valid_ff   <= valid_in;
         dist_ff    <= dist_in;
         age_ff     <= age_in;
      end
   end

   // Window bytes and byte history only matter once counted in, so carry no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < 11; i++) begin
         win_ff[i] <= win_in[i];
      end
      dod_ff  <= dod_in;
      hist_ff <= hist_in;
   end

   lrfp_fifo #(
      .WIDTH ($bits(lrfp_pkg::rsp_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (fire),
      .wdata (result),
      .full  (out_full),
      .pop   (pop),
      .rdata (rsp_item),
      .empty (empty)
   );

   // The start delay register is never read; after reset the start sequence uses its reset value
   logic unused_start_delay;
   assign unused_start_delay = ^start_delay_ff;

endmodule

`default_nettype wire

@@ rtl/lrfp_checker.sv @@
// Port-level checks of the laser range frame poller and their binding.
`default_nettype none

module lrfp_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   push,
   input wire lrfp_pkg::req_item_type req_item,
   input wire logic                   full,
   input wire logic                   pop,
   input wire logic                   empty,
   input wire lrfp_pkg::rsp_item_type rsp_item
);

   // Hold a waiting result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("result changed before its transfer");

   // Drop every queued result on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

   a_send_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.send_request != 2'd3))
      else $error("undefined request code");

   // A fresh measurement is valid, of age zero, carries no request and ends any reply wait
   a_fresh: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.new_measurement) |->
         (rsp_item.distance_valid && rsp_item.age_ms == 14'd0 &&
          !rsp_item.awaiting_reply && rsp_item.send_request == lrfp_pkg::SEND_NONE))
      else $error("inconsistent fresh measurement");

   a_invalid_age: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.distance_valid) |-> (rsp_item.age_ms == lrfp_pkg::AGE_MAX))
      else $error("invalid distance without saturated age");

   logic unused_inputs;
   assign unused_inputs = push ^ full ^ (^req_item);

endmodule

bind laser_range_frame_poller lrfp_checker u_lrfp_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .req_item (req_item),
   .full     (full),
   .pop      (pop),
   .empty    (empty),
   .rsp_item (rsp_item)
);

`default_nettype wire
